// ===== rtl/assert_macros.svh =====
// Assertion helpers for the planner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("check failed");
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`else
`define CHK_ALWAYS(lbl, clk, rst_n, cond)
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/bfdcp_pkg.sv =====
`timescale 1ns / 1ps
package bfdcp_pkg;
    localparam int MAX_BARS_DEF    = 16;
    localparam int MAX_PIECES_DEF  = 32;
    localparam int LENGTH_BITS_DEF = 24;

    localparam int ID_W    = 16;
    localparam int LEN_W   = 24;
    localparam int LOSS_W  = 16;
    localparam int WASTE_W = 28;

    localparam logic [1:0] OP_LOAD_BAR   = 2'd0;
    localparam logic [1:0] OP_LOAD_PIECE = 2'd1;
    localparam logic [1:0] OP_RUN        = 2'd2;

    localparam logic [1:0] KIND_PIECE = 2'd0;
    localparam logic [1:0] KIND_BAR   = 2'd1;
    localparam logic [1:0] KIND_FINAL = 2'd2;
endpackage

// ===== rtl/best_fit_decreasing_cut_planner.sv =====
`timescale 1ns / 1ps
// Loads of bars and pieces produce no output transfer.
// A run repeats, for each piece, a scan of the piece memory for the longest piece left,
// then a three-stage scan of the bar memory and a piece record; a last piece scan
// finds none left, each used bar is read and reported, and a final record gives the
// totals. Any output stall holds the run. Reset clears counts, flags and the output
// valid flag; the memories keep their contents and need no clearing pass.
`include "assert_macros.svh"
module best_fit_decreasing_cut_planner #(
    parameter int MAX_BARS    = bfdcp_pkg::MAX_BARS_DEF,
    parameter int MAX_PIECES  = bfdcp_pkg::MAX_PIECES_DEF,
    parameter int LENGTH_BITS = bfdcp_pkg::LENGTH_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // item_id, item_length, cut_loss
    input  logic [55:0]  s_axis_tdata,
    // opcode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // piece_id, bar_id, assigned, used_length, remaining_length, total_waste,
    // load_overflow, two zero bits
    output logic [111:0] m_axis_tdata,
    // record_kind
    output logic [1:0]   m_axis_tuser,
    // last_record
    output logic         m_axis_tlast
);
    localparam int LW  = LENGTH_BITS;
    localparam int BI  = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
    localparam int BCW = $clog2(MAX_BARS + 1);
    localparam int PI  = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
    localparam int PCW = $clog2(MAX_PIECES + 1);
    localparam int CW  = (PCW > BCW) ? PCW : BCW;
    localparam int NW  = ((LW > bfdcp_pkg::LOSS_W) ? LW : bfdcp_pkg::LOSS_W) + 2;
    localparam int WW  = ((LW > bfdcp_pkg::WASTE_W) ? LW : bfdcp_pkg::WASTE_W) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PSCAN = 3'd1;
    localparam logic [2:0] S_BSCAN = 3'd2;
    localparam logic [2:0] S_PEMIT = 3'd3;
    localparam logic [2:0] S_SRD   = 3'd4;
    localparam logic [2:0] S_SEMIT = 3'd5;
    localparam logic [2:0] S_FEMIT = 3'd6;

    typedef struct packed {
        logic [15:0]   ident;
        logic [15:0]   kerf;
        logic [LW-1:0] rem;
        logic [LW-1:0] cons;
    } bar_ent_t;

    typedef struct packed {
        logic [15:0]   ident;
        logic [LW-1:0] len;
    } piece_ent_t;

    bar_ent_t   bar_mem [MAX_BARS];
    piece_ent_t piece_mem [MAX_PIECES];
    bar_ent_t   bar_rd_reg;
    piece_ent_t piece_rd_reg;

    logic           bar_we, bar_re, piece_we, piece_re;
    logic [BI-1:0]  bar_wa, bar_ra;
    logic [PI-1:0]  piece_wa, piece_ra;
    bar_ent_t       bar_wd;
    piece_ent_t     piece_wd;

    always_ff @(posedge clk)
    begin
        if (bar_we)
        begin
            bar_mem[bar_wa] <= bar_wd;
        end
        if (bar_re)
        begin
            bar_rd_reg <= bar_mem[bar_ra];
        end
        if (piece_we)
        begin
            piece_mem[piece_wa] <= piece_wd;
        end
        if (piece_re)
        begin
            piece_rd_reg <= piece_mem[piece_ra];
        end
    end

    logic [2:0]          state_reg;
    logic [BCW-1:0]      bar_cnt_reg, used_cnt_reg;
    logic [PCW-1:0]      piece_cnt_reg;
    logic                ovf_reg;
    logic [MAX_BARS-1:0] in_use_reg;
    logic [BI-1:0]       fu_reg [MAX_BARS];
    logic [MAX_PIECES-1:0] done_reg;
    logic [CW-1:0]       cnt_reg;
    logic [BCW-1:0]      j_reg;

    logic                pv_reg;
    logic [PI-1:0]       pidx_reg;
    logic                pfound_reg;
    logic [PI-1:0]       pbest_reg;
    logic [LW-1:0]       plen_reg;
    logic [15:0]         pid_reg;

    logic                v1_reg, v2_reg, v3_reg;
    logic [BI-1:0]       i1_reg, i2_reg, i3_reg;
    logic [NW-1:0]       need2_reg, need3_reg;
    bar_ent_t            e2_reg, e3_reg;
    logic                fit3_reg;
    logic [LW-1:0]       r3_reg;
    logic                bfound_reg;
    logic [BI-1:0]       bidx_reg;
    logic [LW-1:0]       brem_reg;
    logic [NW-1:0]       bneed_reg;
    bar_ent_t            bbest_reg;
    logic [WW-1:0]       waste_reg;

    logic                ovalid_reg;
    logic [1:0]          okind_reg;
    logic [15:0]         opid_reg, obid_reg;
    logic                oasg_reg, oovf_reg, olast_reg;
    logic [23:0]         oused_reg, orem_reg;
    logic [27:0]         owaste_reg;

    logic                ofree, accept, emit;
    logic [63:0]         len_ext;
    logic [LW-1:0]       len_in;
    logic [NW-1:0]       diff2;
    logic [WW-1:0]       waste_sum;
    logic [63:0]         brem_ext, rd_rem_ext, rd_cons_ext;
    logic [15:0]         in_id, in_loss;

    assign ofree         = !ovalid_reg || m_axis_tready;
    assign emit          = ofree && (state_reg == S_PEMIT || state_reg == S_SEMIT
                                     || state_reg == S_FEMIT);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_id         = s_axis_tdata[15:0];
    assign in_loss       = s_axis_tdata[55:40];
    assign len_ext       = {40'd0, s_axis_tdata[39:16]};
    assign len_in        = len_ext[LW-1:0];
    assign diff2         = NW'(e2_reg.rem) - need2_reg;
    assign waste_sum     = waste_reg + WW'(bar_rd_reg.rem);
    assign brem_ext      = 64'(brem_reg);
    assign rd_rem_ext    = 64'(bar_rd_reg.rem);
    assign rd_cons_ext   = 64'(bar_rd_reg.cons);

    always_comb
    begin
        bar_we   = 1'b0;
        bar_wa   = bar_cnt_reg[BI-1:0];
        bar_wd   = '{ident: in_id, kerf: in_loss, rem: len_in, cons: '0};
        piece_we = 1'b0;
        piece_wa = piece_cnt_reg[PI-1:0];
        piece_wd = '{ident: in_id, len: len_in};
        bar_re   = 1'b0;
        bar_ra   = cnt_reg[BI-1:0];
        piece_re = 1'b0;
        piece_ra = cnt_reg[PI-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && s_axis_tuser == bfdcp_pkg::OP_LOAD_BAR
                    && bar_cnt_reg < BCW'(MAX_BARS))
                begin
                    bar_we = 1'b1;
                end
                if (accept && s_axis_tuser == bfdcp_pkg::OP_LOAD_PIECE
                    && piece_cnt_reg < PCW'(MAX_PIECES))
                begin
                    piece_we = 1'b1;
                end
            end
            S_PSCAN:
            begin
                piece_re = (cnt_reg < CW'(piece_cnt_reg));
            end
            S_BSCAN:
            begin
                bar_re = (cnt_reg < CW'(bar_cnt_reg));
            end
            S_PEMIT:
            begin
                if (ofree && bfound_reg)
                begin
                    bar_we = 1'b1;
                    bar_wa = bidx_reg;
                    bar_wd = '{ident: bbest_reg.ident, kerf: bbest_reg.kerf,
                               rem: brem_reg,
                               cons: bbest_reg.cons + bneed_reg[LW-1:0]};
                end
            end
            S_SRD:
            begin
                bar_re = (j_reg != used_cnt_reg);
                bar_ra = fu_reg[j_reg[BI-1:0]];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bar_cnt_reg   <= '0;
            used_cnt_reg  <= '0;
            piece_cnt_reg <= '0;
            ovf_reg       <= 1'b0;
            in_use_reg    <= '0;
            done_reg      <= '0;
            cnt_reg       <= '0;
            j_reg         <= '0;
            pv_reg        <= 1'b0;
            pfound_reg    <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            bfound_reg    <= 1'b0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            ovalid_reg <= emit || (ovalid_reg && !m_axis_tready);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (s_axis_tuser)
                            bfdcp_pkg::OP_LOAD_BAR:
                            begin
                                if (bar_cnt_reg < BCW'(MAX_BARS))
                                begin
                                    in_use_reg[bar_cnt_reg[BI-1:0]] <= 1'b0;
                                    bar_cnt_reg <= bar_cnt_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            bfdcp_pkg::OP_LOAD_PIECE:
                            begin
                                if (piece_cnt_reg < PCW'(MAX_PIECES))
                                begin
                                    piece_cnt_reg <= piece_cnt_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            bfdcp_pkg::OP_RUN:
                            begin
                                done_reg   <= '0;
                                waste_reg  <= '0;
                                cnt_reg    <= '0;
                                pv_reg     <= 1'b0;
                                pfound_reg <= 1'b0;
                                state_reg  <= S_PSCAN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_PSCAN:
                begin
                    pv_reg   <= piece_re;
                    pidx_reg <= cnt_reg[PI-1:0];
                    if (piece_re)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (pv_reg && !done_reg[pidx_reg]
                        && (!pfound_reg || piece_rd_reg.len > plen_reg))
                    begin
                        pfound_reg <= 1'b1;
                        pbest_reg  <= pidx_reg;
                        plen_reg   <= piece_rd_reg.len;
                        pid_reg    <= piece_rd_reg.ident;
                    end
                    if (!piece_re && !pv_reg)
                    begin
                        cnt_reg <= '0;
                        if (pfound_reg)
                        begin
                            done_reg[pbest_reg] <= 1'b1;
                            v1_reg     <= 1'b0;
                            v2_reg     <= 1'b0;
                            v3_reg     <= 1'b0;
                            bfound_reg <= 1'b0;
                            state_reg  <= S_BSCAN;
                        end
                        else
                        begin
                            j_reg     <= '0;
                            state_reg <= S_SRD;
                        end
                    end
                end
                S_BSCAN:
                begin
                    v1_reg    <= bar_re;
                    i1_reg    <= cnt_reg[BI-1:0];
                    if (bar_re)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    v2_reg    <= v1_reg;
                    i2_reg    <= i1_reg;
                    e2_reg    <= bar_rd_reg;
                    need2_reg <= NW'(plen_reg) + NW'(bar_rd_reg.kerf);
                    v3_reg    <= v2_reg;
                    i3_reg    <= i2_reg;
                    e3_reg    <= e2_reg;
                    need3_reg <= need2_reg;
                    fit3_reg  <= !diff2[NW-1];
                    r3_reg    <= diff2[LW-1:0];
                    if (v3_reg && fit3_reg && (!bfound_reg || r3_reg < brem_reg))
                    begin
                        bfound_reg <= 1'b1;
                        bidx_reg   <= i3_reg;
                        brem_reg   <= r3_reg;
                        bneed_reg  <= need3_reg;
                        bbest_reg  <= e3_reg;
                    end
                    if (!bar_re && !v1_reg && !v2_reg && !v3_reg)
                    begin
                        state_reg <= S_PEMIT;
                    end
                end
                S_PEMIT:
                begin
                    if (ofree)
                    begin
                        okind_reg  <= bfdcp_pkg::KIND_PIECE;
                        opid_reg   <= pid_reg;
                        obid_reg   <= bfound_reg ? bbest_reg.ident : 16'd0;
                        oasg_reg   <= bfound_reg;
                        oused_reg  <= '0;
                        orem_reg   <= bfound_reg ? brem_ext[23:0] : 24'd0;
                        owaste_reg <= '0;
                        oovf_reg   <= 1'b0;
                        olast_reg  <= 1'b0;
                        if (bfound_reg && !in_use_reg[bidx_reg])
                        begin
                            in_use_reg[bidx_reg] <= 1'b1;
                            fu_reg[used_cnt_reg[BI-1:0]] <= bidx_reg;
                            used_cnt_reg <= used_cnt_reg + 1'b1;
                        end
                        cnt_reg    <= '0;
                        pv_reg     <= 1'b0;
                        pfound_reg <= 1'b0;
                        state_reg  <= S_PSCAN;
                    end
                end
                S_SRD:
                begin
                    state_reg <= (j_reg == used_cnt_reg) ? S_FEMIT : S_SEMIT;
                end
                S_SEMIT:
                begin
                    if (ofree)
                    begin
                        okind_reg  <= bfdcp_pkg::KIND_BAR;
                        opid_reg   <= '0;
                        obid_reg   <= bar_rd_reg.ident;
                        oasg_reg   <= 1'b0;
                        oused_reg  <= rd_cons_ext[23:0];
                        orem_reg   <= rd_rem_ext[23:0];
                        owaste_reg <= '0;
                        oovf_reg   <= 1'b0;
                        olast_reg  <= 1'b0;
                        waste_reg  <= (waste_sum > WW'(28'hFFFFFFF)) ? WW'(28'hFFFFFFF)
                                                                    : waste_sum;
                        j_reg      <= j_reg + 1'b1;
                        state_reg  <= S_SRD;
                    end
                end
                S_FEMIT:
                begin
                    if (ofree)
                    begin
                        okind_reg     <= bfdcp_pkg::KIND_FINAL;
                        opid_reg      <= '0;
                        obid_reg      <= '0;
                        oasg_reg      <= 1'b0;
                        oused_reg     <= '0;
                        orem_reg      <= '0;
                        owaste_reg    <= waste_reg[27:0];
                        oovf_reg      <= ovf_reg;
                        olast_reg     <= 1'b1;
                        bar_cnt_reg   <= '0;
                        piece_cnt_reg <= '0;
                        used_cnt_reg  <= '0;
                        ovf_reg       <= 1'b0;
                        in_use_reg    <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {2'b00, oovf_reg, owaste_reg, orem_reg, oused_reg,
                            oasg_reg, obid_reg, opid_reg};

    `CHK_ALWAYS(a_used_le_bars, clk, rst_n, used_cnt_reg <= bar_cnt_reg)
    `CHK_ALWAYS(a_pieces_bound, clk, rst_n, piece_cnt_reg <= PCW'(MAX_PIECES))
    `CHK_IMPLY(a_last_is_final, clk, rst_n, m_axis_tvalid && m_axis_tlast,
               m_axis_tuser == bfdcp_pkg::KIND_FINAL)
    `CHK_IMPLY(a_ready_idle, clk, rst_n, state_reg != S_IDLE, !s_axis_tready)
endmodule
